@@ design/midpoint_ellipse_rasterizer_defines.svh @@
// Assertion macros shared by the midpoint ellipse rasterizer RTL.
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_DEFINES_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define MER_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define MER_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/mer_pkg.sv @@
// Widths, codes and sequencer states of the midpoint ellipse rasterizer.
package mer_pkg;

    localparam int RADIUS_BITS = 10;
    localparam int COORD_BITS  = 11;
    localparam int SQ_BITS     = 2 * RADIUS_BITS;
    localparam int ODD_BITS    = COORD_BITS + 1;
    localparam int PIX_BITS    = COORD_BITS + 2;
    localparam int MUL_A_BITS  = (SQ_BITS > ODD_BITS) ? SQ_BITS : ODD_BITS;
    localparam int MUL_B_BITS  = (2 * ODD_BITS > SQ_BITS) ? 2 * ODD_BITS : SQ_BITS;
    localparam int PROD_BITS   = MUL_A_BITS + MUL_B_BITS;
    localparam int DEC_BITS    = PROD_BITS;
    localparam int ACC_BITS    = PROD_BITS + 3;

    // operation field
    localparam logic OP_START   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    // drawing region
    typedef logic [1:0] t_region;
    localparam t_region REG_IDLE = 2'd0;
    localparam t_region REG_ONE  = 2'd1;
    localparam t_region REG_TWO  = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_A2,
        ST_B2,
        ST_I1M,
        ST_I1S,
        ST_TRUNC,
        ST_R1C1,
        ST_R1C2,
        ST_R1CMP,
        ST_ADDB,
        ST_ACCUM,
        ST_R2C1,
        ST_R2C2,
        ST_R2C3,
        ST_Q1,
        ST_Q2,
        ST_Q3,
        ST_Q4,
        ST_Q5,
        ST_Q6,
        ST_EMIT
    } t_state;

endpackage

@@ design/mer_mul.sv @@
// Shared unsigned multiplier with a registered product.
module mer_mul (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [mer_pkg::MUL_A_BITS-1:0] i_a,
    input  logic [mer_pkg::MUL_B_BITS-1:0] i_b,
    output logic [mer_pkg::PROD_BITS-1:0]  o_prod
);
    import mer_pkg::*;

    logic [PROD_BITS-1:0] r_prod;

    // product holds until the sequencer asks for a new one
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= PROD_BITS'(i_a) * PROD_BITS'(i_b);
        end
    end

    assign o_prod = r_prod;

endmodule

@@ design/midpoint_ellipse_rasterizer.sv @@
// Midpoint ellipse rasterizer: sequencer, decision datapath and pixel output.
//
//  channel  | valid   | ready   | payload
//  ---------+---------+---------+--------------------------------------------------
//  input    | i_valid | o_ready | i_operation, i_radius_x/y, i_center_x/y
//  output   | o_valid | i_ready | o_pixel_x, o_pixel_y, o_last_pixel
//
//  One multiplier and one accumulator are shared by every step, so each runs a multiply
//  sequence: start A2, B2, I1M, I1S, TRUNC; region-1 step R1C1, R1C2, R1CMP, ADDB, ACCUM;
//  region-2 step R2C1, R2C2, R2C3, ACCUM; entering region 2 ends in Q1 to Q6, TRUNC; then
//  EMIT, four pixels. Zero radius_y: start goes straight to EMIT; empty advance stays idle.
//  o_ready is high only while idle; the output register keeps its pixel until taken.
//  Synchronous active-low reset returns the block to idle with no ellipse in progress.
`include "midpoint_ellipse_rasterizer_defines.svh"

module midpoint_ellipse_rasterizer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_operation,
    input  logic [mer_pkg::RADIUS_BITS-1:0]     i_radius_x,
    input  logic [mer_pkg::RADIUS_BITS-1:0]     i_radius_y,
    input  logic [mer_pkg::COORD_BITS-1:0]      i_center_x,
    input  logic [mer_pkg::COORD_BITS-1:0]      i_center_y,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [mer_pkg::PIX_BITS-1:0] o_pixel_x,
    output logic signed [mer_pkg::PIX_BITS-1:0] o_pixel_y,
    output logic                                o_last_pixel
);
    import mer_pkg::*;

    // control state
    t_state  r_state,  n_state;
    t_region r_region, n_region;
    logic    r_ovalid, n_ovalid;
    logic [1:0] r_k, n_k;

    // payload state
    logic [RADIUS_BITS-1:0] r_rx, n_rx, r_ry, n_ry;
    logic [COORD_BITS-1:0]  r_cx, n_cx, r_cy, n_cy;
    logic [COORD_BITS-1:0]  r_off_x, n_off_x;
    logic [RADIUS_BITS-1:0] r_off_y, n_off_y;
    logic [SQ_BITS-1:0]     r_a2, n_a2, r_b2, n_b2;
    logic signed [DEC_BITS-1:0] r_dec, n_dec;
    logic signed [ACC_BITS-1:0] r_acc, n_acc;
    logic r_diag, n_diag;
    logic r_last, n_last;
    logic signed [PIX_BITS-1:0] r_px, n_px, r_py, n_py;
    logic r_olast, n_olast;

    // multiplier interface
    logic                  mul_en;
    logic [MUL_A_BITS-1:0] mul_a;
    logic [MUL_B_BITS-1:0] mul_b;
    logic [PROD_BITS-1:0]  prod;

    // extended terms
    logic signed [ACC_BITS-1:0] prod_x1, prod_x2, prod_x4, a2_ext, b2_ext, dec_ext;
    logic signed [ACC_BITS-1:0] diff, acc_sum, quarter;
    logic [PIX_BITS-1:0] cx_e, cy_e, x_e, y_e;
    logic in_fire;

    mer_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (mul_en),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    assign in_fire = i_valid && o_ready;

    assign prod_x1 = {{(ACC_BITS-PROD_BITS){1'b0}}, prod};
    assign prod_x2 = prod_x1 <<< 1;
    assign prod_x4 = prod_x1 <<< 2;
    assign a2_ext  = {{(ACC_BITS-SQ_BITS){1'b0}}, r_a2};
    assign b2_ext  = {{(ACC_BITS-SQ_BITS){1'b0}}, r_b2};
    assign dec_ext = {{(ACC_BITS-DEC_BITS){r_dec[DEC_BITS-1]}}, r_dec};

    // region-1 test c1 - c2, and the decision update sum
    assign diff    = r_acc - prod_x2;
    assign acc_sum = dec_ext + r_acc;

    // divide by four, truncating toward zero
    always_comb begin
        quarter = r_acc >>> 2;
        if (r_acc[ACC_BITS-1] && (r_acc[1:0] != 2'b00)) begin
            quarter = quarter + ACC_BITS'(1);
        end
    end

    // mirrored pixel operands
    assign cx_e = {{(PIX_BITS-COORD_BITS){1'b0}}, r_cx};
    assign cy_e = {{(PIX_BITS-COORD_BITS){1'b0}}, r_cy};
    assign x_e  = {{(PIX_BITS-COORD_BITS){1'b0}}, r_off_x};
    assign y_e  = {{(PIX_BITS-RADIUS_BITS){1'b0}}, r_off_y};

    // sequencer: next state, datapath and multiplier control
    always_comb begin
        n_state  = r_state;
        n_region = r_region;
        n_ovalid = r_ovalid;
        n_k      = r_k;
        n_rx     = r_rx;
        n_ry     = r_ry;
        n_cx     = r_cx;
        n_cy     = r_cy;
        n_off_x  = r_off_x;
        n_off_y  = r_off_y;
        n_a2     = r_a2;
        n_b2     = r_b2;
        n_dec    = r_dec;
        n_acc    = r_acc;
        n_diag   = r_diag;
        n_last   = r_last;
        n_px     = r_px;
        n_py     = r_py;
        n_olast  = r_olast;
        mul_en   = 1'b0;
        mul_a    = '0;
        mul_b    = '0;

        // output register empties when taken
        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    if (i_operation == OP_START) begin
                        n_rx    = i_radius_x;
                        n_ry    = i_radius_y;
                        n_cx    = i_center_x;
                        n_cy    = i_center_y;
                        n_off_x = '0;
                        n_off_y = i_radius_y;
                        n_k     = '0;
                        if (i_radius_y == '0) begin
                            n_region = REG_IDLE;
                            n_dec    = '0;
                            n_last   = 1'b1;
                            n_state  = ST_EMIT;
                        end else begin
                            n_region = REG_ONE;
                            n_state  = ST_A2;
                        end
                    end else if (r_region == REG_ONE) begin
                        n_diag  = !r_dec[DEC_BITS-1];
                        n_off_x = r_off_x + COORD_BITS'(1);
                        if (!r_dec[DEC_BITS-1]) begin
                            n_off_y = r_off_y - RADIUS_BITS'(1);
                        end
                        n_state = ST_R1C1;
                    end else if (r_region == REG_TWO) begin
                        if (r_off_y == '0) begin
                            n_region = REG_IDLE;
                        end else begin
                            // diag here means a vertical-only step
                            n_diag  = !r_dec[DEC_BITS-1] && (r_dec != '0);
                            n_off_y = r_off_y - RADIUS_BITS'(1);
                            if (r_dec[DEC_BITS-1] || (r_dec == '0)) begin
                                n_off_x = r_off_x + COORD_BITS'(1);
                            end
                            n_acc   = a2_ext;
                            n_state = ST_R2C1;
                        end
                    end
                end
            end

            // start: rx^2, ry^2, then 4*ry^2 + rx^2 - 4*rx^2*ry
            ST_A2: begin
                mul_en  = 1'b1;
                mul_a   = MUL_A_BITS'(r_rx);
                mul_b   = MUL_B_BITS'(r_rx);
                n_state = ST_B2;
            end
            ST_B2: begin
                n_a2    = prod[SQ_BITS-1:0];
                mul_en  = 1'b1;
                mul_a   = MUL_A_BITS'(r_ry);
                mul_b   = MUL_B_BITS'(r_ry);
                n_state = ST_I1M;
            end
            ST_I1M: begin
                n_b2    = prod[SQ_BITS-1:0];
                n_acc   = prod_x4 + a2_ext;
                mul_en  = 1'b1;
                mul_a   = MUL_A_BITS'(r_a2);
                mul_b   = MUL_B_BITS'(r_ry);
                n_state = ST_I1S;
            end
            ST_I1S: begin
                n_acc   = r_acc - prod_x4;
                n_state = ST_TRUNC;
            end
            ST_TRUNC: begin
                n_dec   = quarter[DEC_BITS-1:0];
                n_last  = 1'b0;
                n_k     = '0;
                n_state = ST_EMIT;
            end

            // region 1: c1 = 2*b2*x, c2 = 2*a2*y
            ST_R1C1: begin
                mul_en  = 1'b1;
                mul_a   = MUL_A_BITS'(r_b2);
                mul_b   = MUL_B_BITS'(r_off_x);
                n_state = ST_R1C2;
            end
            ST_R1C2: begin
                n_acc   = prod_x2;
                mul_en  = 1'b1;
                mul_a   = MUL_A_BITS'(r_a2);
                mul_b   = MUL_B_BITS'(r_off_y);
                n_state = ST_R1CMP;
            end
            ST_R1CMP: begin
                if (!diff[ACC_BITS-1]) begin
                    if (r_off_y == '0) begin
                        n_region = REG_IDLE;
                        n_last   = 1'b1;
                        n_k      = '0;
                        n_state  = ST_EMIT;
                    end else begin
                        n_region = REG_TWO;
                        n_state  = ST_Q1;
                    end
                end else begin
                    if (r_diag) begin
                        n_acc = diff;
                    end
                    n_state = ST_ADDB;
                end
            end
            ST_ADDB: begin
                n_acc   = r_acc + b2_ext;
                n_state = ST_ACCUM;
            end

            // common decision update; the ellipse ends at y zero
            ST_ACCUM: begin
                n_dec = acc_sum[DEC_BITS-1:0];
                if (r_off_y == '0) begin
                    n_region = REG_IDLE;
                    n_last   = 1'b1;
                end else begin
                    n_last   = 1'b0;
                end
                n_k     = '0;
                n_state = ST_EMIT;
            end

            // region 2: a2 + (diagonal ? c1 : 0) - c2
            ST_R2C1: begin
                mul_en  = 1'b1;
                mul_a   = MUL_A_BITS'(r_b2);
                mul_b   = MUL_B_BITS'(r_off_x);
                n_state = ST_R2C2;
            end
            ST_R2C2: begin
                if (!r_diag) begin
                    n_acc = r_acc + prod_x2;
                end
                mul_en  = 1'b1;
                mul_a   = MUL_A_BITS'(r_a2);
                mul_b   = MUL_B_BITS'(r_off_y);
                n_state = ST_R2C3;
            end
            ST_R2C3: begin
                n_acc   = r_acc - prod_x2;
                n_state = ST_ACCUM;
            end

            // region-2 entry: b2*(2x+1)^2 + 4*a2*(y-1)^2 - 4*a2*b2
            ST_Q1: begin
                mul_en  = 1'b1;
                mul_a   = MUL_A_BITS'({r_off_x, 1'b1});
                mul_b   = MUL_B_BITS'({r_off_x, 1'b1});
                n_state = ST_Q2;
            end
            ST_Q2: begin
                mul_en  = 1'b1;
                mul_a   = MUL_A_BITS'(r_b2);
                mul_b   = prod[MUL_B_BITS-1:0];
                n_state = ST_Q3;
            end
            ST_Q3: begin
                n_acc   = prod_x1;
                mul_en  = 1'b1;
                mul_a   = MUL_A_BITS'(r_off_y - RADIUS_BITS'(1));
                mul_b   = MUL_B_BITS'(r_off_y - RADIUS_BITS'(1));
                n_state = ST_Q4;
            end
            ST_Q4: begin
                mul_en  = 1'b1;
                mul_a   = MUL_A_BITS'(r_a2);
                mul_b   = prod[MUL_B_BITS-1:0];
                n_state = ST_Q5;
            end
            ST_Q5: begin
                n_acc   = r_acc + prod_x4;
                mul_en  = 1'b1;
                mul_a   = MUL_A_BITS'(r_a2);
                mul_b   = MUL_B_BITS'(r_b2);
                n_state = ST_Q6;
            end
            ST_Q6: begin
                n_acc   = r_acc - prod_x4;
                n_state = ST_TRUNC;
            end

            // four mirrored pixels, one per free output slot
            ST_EMIT: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_px     = r_k[0] ? $signed(cx_e - x_e) : $signed(cx_e + x_e);
                    n_py     = r_k[1] ? $signed(cy_e - y_e) : $signed(cy_e + y_e);
                    n_olast  = r_last && (r_k == 2'd3);
                    n_k      = r_k + 2'd1;
                    if (r_k == 2'd3) begin
                        n_state = ST_IDLE;
                    end
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_region <= REG_IDLE;
            r_ovalid <= 1'b0;
            r_k      <= '0;
        end else begin
            r_state  <= n_state;
            r_region <= n_region;
            r_ovalid <= n_ovalid;
            r_k      <= n_k;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rx    <= n_rx;
        r_ry    <= n_ry;
        r_cx    <= n_cx;
        r_cy    <= n_cy;
        r_off_x <= n_off_x;
        r_off_y <= n_off_y;
        r_a2    <= n_a2;
        r_b2    <= n_b2;
        r_dec   <= n_dec;
        r_acc   <= n_acc;
        r_diag  <= n_diag;
        r_last  <= n_last;
        r_px    <= n_px;
        r_py    <= n_py;
        r_olast <= n_olast;
    end

    assign o_ready      = (r_state == ST_IDLE);
    assign o_valid      = r_ovalid;
    assign o_pixel_x    = r_px;
    assign o_pixel_y    = r_py;
    assign o_last_pixel = r_olast;

    // a flagged final step always leaves the block with no ellipse in progress
    `MER_ASSERT_IMP(a_last_idle, i_clk, i_rst_n, (r_state == ST_EMIT) && r_last, r_region == REG_IDLE, "last step left a region active")
    // a stalled output slot holds the pixel sequence in place
    `MER_ASSERT_NXT(a_emit_hold, i_clk, i_rst_n, (r_state == ST_EMIT) && r_ovalid && !i_ready, (r_k == $past(r_k)) && (r_state == ST_EMIT), "pixel sequence advanced while stalled")
    // region 2 parked between steps always has rows left
    `MER_ASSERT_IMP(a_reg2_rows, i_clk, i_rst_n, (r_state == ST_IDLE) && (r_region == REG_TWO), r_off_y != '0, "region 2 idle at row zero")

endmodule

@@ tb/midpoint_ellipse_rasterizer_tb.sv @@
// Self-checking testbench of the midpoint ellipse rasterizer: directed table, then random ellipses.
module midpoint_ellipse_rasterizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mer_pkg::*;

    typedef logic [PIX_BITS-1:0] t_pix;

    typedef struct {
        t_pix px;
        t_pix py;
        logic last;
    } t_pixel_item;

    // one directed item; literal rows carry the pixels to expect
    typedef struct {
        logic op;
        int   rx;
        int   ry;
        int   cx;
        int   cy;
        bit   lit;
        int   xp;
        int   xm;
        int   yp;
        int   ym;
        bit   last;
    } t_dir_row;

    localparam int RANDOM_ITEMS = 250;
    localparam int PHASE_ITEMS  = 60;

    logic                   i_clk        = 1'b0;
    logic                   i_rst_n      = 1'b0;
    logic                   i_valid      = 1'b0;
    logic                   o_ready;
    logic                   i_operation  = OP_START;
    logic [RADIUS_BITS-1:0] i_radius_x   = '0;
    logic [RADIUS_BITS-1:0] i_radius_y   = '0;
    logic [COORD_BITS-1:0]  i_center_x   = '0;
    logic [COORD_BITS-1:0]  i_center_y   = '0;
    logic                   o_valid;
    logic                   i_ready      = 1'b0;
    logic signed [PIX_BITS-1:0] o_pixel_x;
    logic signed [PIX_BITS-1:0] o_pixel_y;
    logic                   o_last_pixel;

    midpoint_ellipse_rasterizer dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_operation  (i_operation),
        .i_radius_x   (i_radius_x),
        .i_radius_y   (i_radius_y),
        .i_center_x   (i_center_x),
        .i_center_y   (i_center_y),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_pixel_x    (o_pixel_x),
        .o_pixel_y    (o_pixel_y),
        .o_last_pixel (o_last_pixel)
    );

    always #4 i_clk = ~i_clk;

    // pixels still to come out of the block, oldest first
    t_pixel_item expected_pixels[$];
    int          mismatches    = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          drawn_items   = 0;

    // shadow of the rasterizer state
    int      pos_x       = 0;
    int      pos_y       = 0;
    longint  decision_acc = 0;
    t_region draw_region = REG_IDLE;
    longint  rad_x       = 0;
    longint  rad_y       = 0;
    int      ctr_x       = 0;
    int      ctr_y       = 0;

    // four mirrored pixels, flag on the fourth
    function automatic void push_quad(int xp, int xm, int yp, int ym, bit last);
        t_pixel_item p;
        for (int k = 0; k < 4; k++) begin
            p.px   = t_pix'((k % 2 == 0) ? xp : xm);
            p.py   = t_pix'((k < 2) ? yp : ym);
            p.last = last && (k == 3);
            expected_pixels.push_back(p);
        end
    endfunction

    // one step of the midpoint rule; returns how many pixels it plots
    function automatic int rasterize_step(logic op, int rx, int ry, int cx, int cy, bit record);
        longint a2;
        longint b2;
        longint c1;
        longint c2;
        longint xl;
        longint yl;
        bit     diag;
        bit     last;
        last = 1'b0;
        if (op == OP_START) begin
            rad_x = rx;
            rad_y = ry;
            ctr_x = cx;
            ctr_y = cy;
            pos_x = 0;
            pos_y = ry;
            if (ry == 0) begin
                draw_region  = REG_IDLE;
                decision_acc = 0;
                last = 1'b1;
            end else begin
                a2 = rad_x * rad_x;
                b2 = rad_y * rad_y;
                decision_acc = (4 * b2 - 4 * a2 * rad_y + a2) / 4;
                draw_region  = REG_ONE;
            end
        end else if (draw_region == REG_ONE) begin
            a2 = rad_x * rad_x;
            b2 = rad_y * rad_y;
            diag = decision_acc >= 0;
            pos_x++;
            if (diag) pos_y--;
            xl = pos_x;
            yl = pos_y;
            c1 = 2 * b2 * xl;
            c2 = 2 * a2 * yl;
            if (c1 >= c2) begin
                if (pos_y == 0) begin
                    draw_region = REG_IDLE;
                    last = 1'b1;
                end else begin
                    draw_region  = REG_TWO;
                    decision_acc = (b2 * (2 * xl + 1) * (2 * xl + 1)
                                    + 4 * a2 * (yl - 1) * (yl - 1) - 4 * a2 * b2) / 4;
                end
            end else begin
                decision_acc += diag ? (c1 - c2 + b2) : (c1 + b2);
            end
        end else if (draw_region == REG_TWO) begin
            a2 = rad_x * rad_x;
            b2 = rad_y * rad_y;
            if (pos_y == 0) begin
                draw_region = REG_IDLE;
                return 0;
            end
            if (decision_acc > 0) begin
                pos_y--;
                c2 = 2 * a2 * longint'(pos_y);
                decision_acc += a2 - c2;
            end else begin
                pos_x++;
                pos_y--;
                c1 = 2 * b2 * longint'(pos_x);
                c2 = 2 * a2 * longint'(pos_y);
                decision_acc += c1 - c2 + a2;
            end
            if (pos_y == 0) begin
                draw_region = REG_IDLE;
                last = 1'b1;
            end
        end else begin
            return 0;
        end
        if (record) push_quad(ctr_x + pos_x, ctr_x - pos_x, ctr_y + pos_y, ctr_y - pos_y, last);
        return 4;
    endfunction

    // present one item, hold it until taken, then predict its pixels
    task automatic drive_item(input logic op, input int rx, input int ry, input int cx,
                              input int cy, input bit record, output int nres);
        bit took;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        i_valid     <= 1'b1;
        i_operation <= op;
        i_radius_x  <= RADIUS_BITS'(rx);
        i_radius_y  <= RADIUS_BITS'(ry);
        i_center_x  <= COORD_BITS'(cx);
        i_center_y  <= COORD_BITS'(cy);
        do begin
            @(negedge i_clk);
            took = o_ready;
            @(posedge i_clk);
        end while (!took);
        nres = rasterize_step(op, rx, ry, cx, cy, record);
    endtask

    // advance with junk in the unused fields
    task automatic advance_once;
        int n;
        drive_item(OP_ADVANCE, $urandom_range(0, 1023), $urandom_range(0, 1023),
                   $urandom_range(0, 2047), $urandom_range(0, 2047), 1'b1, n);
        if (n > 0) drawn_items++;
    endtask

    // hold the sender off until every pixel has come out
    task automatic drain_pixels;
        i_valid <= 1'b0;
        do @(posedge i_clk); while (expected_pixels.size() != 0);
    endtask

    // receiver stalls
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // output checker, sampled between edges
    always @(negedge i_clk) begin
        t_pixel_item want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pixel: x=%0d y=%0d last=%b",
                             o_pixel_x, o_pixel_y, o_last_pixel);
            end else begin
                want = expected_pixels.pop_front();
                if (o_pixel_x !== want.px || o_pixel_y !== want.py
                        || o_last_pixel !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("pixel mismatch: expected x=%0d y=%0d last=%b, got x=%0d y=%0d last=%b",
                                 $signed(want.px), $signed(want.py), want.last,
                                 o_pixel_x, o_pixel_y, o_last_pixel);
                end
            end
        end
    end

    // directed items: extremes, restart, degenerate radii, advance while idle
    t_dir_row dir_rows [22] = '{
        '{OP_ADVANCE, 1023, 1023, 2047, 2047, 1, 0, 0, 0, 0, 0},
        '{OP_START,   1023, 1023,    0,    0, 1, 0, 0, 1023, -1023, 0},
        '{OP_ADVANCE,    0,    0,    0,    0, 0, 0, 0, 0, 0, 0},
        '{OP_ADVANCE, 1023, 1023, 2047, 2047, 0, 0, 0, 0, 0, 0},
        '{OP_ADVANCE,    0,    0,    0,    0, 0, 0, 0, 0, 0, 0},
        '{OP_START,   1023, 1023, 2047, 2047, 1, 2047, 2047, 3070, 1024, 0},
        '{OP_ADVANCE,    0,    0,    0,    0, 0, 0, 0, 0, 0, 0},
        '{OP_ADVANCE,    0,    0,    0,    0, 0, 0, 0, 0, 0, 0},
        '{OP_START,   1023,    0,  100,  200, 1, 100, 100, 200, 200, 1},
        '{OP_ADVANCE,  511,  511, 1024, 1024, 1, 0, 0, 0, 0, 0},
        '{OP_START,      0,    0, 2047,    0, 1, 2047, 2047, 0, 0, 1},
        '{OP_START,      0,    3,    5,    5, 0, 0, 0, 0, 0, 0},
        '{OP_ADVANCE,    0,    0,    0,    0, 0, 0, 0, 0, 0, 0},
        '{OP_ADVANCE,    0,    0,    0,    0, 0, 0, 0, 0, 0, 0},
        '{OP_ADVANCE,    0,    0,    0,    0, 0, 0, 0, 0, 0, 0},
        '{OP_ADVANCE,    0,    0,    0,    0, 1, 0, 0, 0, 0, 0},
        '{OP_START,      1,    1, 1000, 1000, 0, 0, 0, 0, 0, 0},
        '{OP_ADVANCE,    0,    0,    0,    0, 0, 0, 0, 0, 0, 0},
        '{OP_START,      2,    1,    0, 2047, 0, 0, 0, 0, 0, 0},
        '{OP_ADVANCE,    0,    0,    0,    0, 0, 0, 0, 0, 0, 0},
        '{OP_ADVANCE,    0,    0,    0,    0, 0, 0, 0, 0, 0, 0},
        '{OP_ADVANCE, 1023, 1023, 2047, 2047, 1, 0, 0, 0, 0, 0}
    };

    // stimulus
    initial begin
        int n;
        int cur_phase;
        int kind;
        int rx;
        int ry;
        int steps;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            drive_item(dir_rows[i].op, dir_rows[i].rx, dir_rows[i].ry, dir_rows[i].cx,
                       dir_rows[i].cy, !dir_rows[i].lit, n);
            if (dir_rows[i].lit && dir_rows[i].op == OP_START)
                push_quad(dir_rows[i].xp, dir_rows[i].xm, dir_rows[i].yp, dir_rows[i].ym,
                          dir_rows[i].last);
        end
        drain_pixels();

        // random ellipses, mostly drawn to the end; each idling phase in turn
        cur_phase = 0;
        while (drawn_items < RANDOM_ITEMS) begin
            if (cur_phase < 3 && drawn_items >= (cur_phase + 1) * PHASE_ITEMS) begin
                drain_pixels();
                cur_phase++;
                case (cur_phase)
                    1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
                    2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
                    default: begin send_idle_pct = 10; recv_stall_pct = 10; end
                endcase
            end
            kind = $urandom_range(0, 99);
            if (kind < 75) begin
                rx = $urandom_range(0, 15);
                ry = $urandom_range(0, 15);
            end else if (kind < 85) begin
                rx = $urandom_range(16, 40);
                ry = $urandom_range(16, 40);
            end else begin
                rx = $urandom_range(0, 1023);
                ry = $urandom_range(0, 1023);
            end
            drive_item(OP_START, rx, ry, $urandom_range(0, 2047), $urandom_range(0, 2047),
                       1'b1, n);
            drawn_items++;
            if (kind < 85) begin
                while (draw_region != REG_IDLE) advance_once();
            end else begin
                // large ellipse: a few steps, then abandoned by the next start
                steps = $urandom_range(0, 12);
                for (int s = 0; s < steps && draw_region != REG_IDLE; s++) advance_once();
            end
            if ($urandom_range(0, 3) == 0) advance_once();
        end

        drain_pixels();
        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && expected_pixels.size() == 0) begin
            $display("midpoint_ellipse_rasterizer_tb passed");
        end else begin
            $display("midpoint_ellipse_rasterizer_tb failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #4000000;
        $display("midpoint_ellipse_rasterizer_tb failed");
        $finish;
    end

endmodule
